>>> src/dgti_pkg.sv
// dgti_pkg: sizes, register indexes and sequencer states of the depth grid interpolator
// used by every module of the block but dgti_ram; depends on nothing

package dgti_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int DEPTH_BITS = 16;
	localparam int FRAC_BITS  = 8;

	localparam int FIELD_BITS = 16;
	localparam int CFG_BITS   = 16;
	localparam int SIZE_BITS  = 9;

	localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_BITS  = $clog2(STORE_SIZE);
	localparam int W_BITS     = $clog2(MAX_WIDTH + 1);
	localparam int H_BITS     = $clog2(MAX_HEIGHT + 1);
	localparam int INT_BITS   = (FIELD_BITS - FRAC_BITS > 0) ? FIELD_BITS - FRAC_BITS : 1;
	localparam int WGT_BITS   = FRAC_BITS + 1;

	localparam int MAC_A_BITS = (DEPTH_BITS > INT_BITS) ? DEPTH_BITS : INT_BITS;
	localparam int MAC_B_BITS = (WGT_BITS > W_BITS) ? WGT_BITS : W_BITS;
	localparam int NUM_BITS   = DEPTH_BITS + FRAC_BITS + 1;
	localparam int ACC_BITS   = (NUM_BITS > ADDR_BITS + 1) ? NUM_BITS : ADDR_BITS + 1;

	typedef enum logic [1:0] {
		CFG_IMAGE_WIDTH   = 2'd0,
		CFG_IMAGE_HEIGHT  = 2'd1,
		CFG_INVALID_DEPTH = 2'd2
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BASE,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_MAC3
	} state_t;

	typedef enum logic {
		MODE_WRITE = 1'b0,
		MODE_QUERY = 1'b1
	} mode_t;

endpackage

>>> src/dgti_ram.sv
// dgti_ram: generic single-port memory with registered read data
// no package needed; sized by its parameters

module dgti_ram #(
	parameter int ADDR_W = 16,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> src/dgti_mac.sv
// dgti_mac: shared multiply-add unit, y = a * b + c
// depends on dgti_pkg for operand and accumulator widths

module dgti_mac
	import dgti_pkg::*;
(
	input  logic [MAC_A_BITS-1:0] a,
	input  logic [MAC_B_BITS-1:0] b,
	input  logic [ACC_BITS-1:0]   c,
	output logic [ACC_BITS-1:0]   y
);

	logic [MAC_A_BITS+MAC_B_BITS-1:0] prod;

	always_comb begin
		prod = (MAC_A_BITS + MAC_B_BITS)'(a) * (MAC_A_BITS + MAC_B_BITS)'(b);
		y    = ACC_BITS'(ACC_BITS'(prod) + c);
	end

endmodule

>>> src/depth_grid_triangle_interpolator.sv
// depth_grid_triangle_interpolator: top level, config registers, sequencer and pixel store
// depends on dgti_pkg, dgti_ram and dgti_mac
//
// channel  | handshake          | payload
// ---------+--------------------+--------------------------------------------------
// config   | cfg_we             | cfg_index, cfg_data
// item in  | start && !busy     | mode, pixel_index, depth_in, query_x, query_y
// result   | done, one cycle    | depth_valid, depth_out
//
// a pixel write is taken while idle and leaves busy low
// a query keeps busy high through ST_BASE (base address on the shared multiply-add),
// ST_RD0 to ST_RD2 (three corner reads from the single-port store) and ST_MAC3;
// done follows in the next cycle; a cell outside the image is answered from ST_BASE
// done cannot be held off; arst_n clears control state only, the store is not cleared

module depth_grid_triangle_interpolator
	import dgti_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [CFG_BITS-1:0]   cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  logic                  mode,
	input  logic [FIELD_BITS-1:0] pixel_index,
	input  logic [FIELD_BITS-1:0] depth_in,
	input  logic [FIELD_BITS-1:0] query_x,
	input  logic [FIELD_BITS-1:0] query_y,
	output logic                  done,
	output logic                  depth_valid,
	output logic [FIELD_BITS-1:0] depth_out
);

	localparam logic [WGT_BITS-1:0] FRAC_ONE  = WGT_BITS'(1) << FRAC_BITS;
	localparam logic [ACC_BITS-1:0] FRAC_HALF = ACC_BITS'(FRAC_ONE >> 1);

	logic [SIZE_BITS-1:0]  image_width_q;
	logic [SIZE_BITS-1:0]  image_height_q;
	logic [CFG_BITS-1:0]   invalid_depth_q;

	state_t                state_q, state_d;
	logic [FIELD_BITS-1:0] qx_q, qy_q;
	logic [ADDR_BITS-1:0]  base_q;
	logic [ACC_BITS-1:0]   acc_q;
	logic                  bad_q;
	logic                  done_q, valid_q;
	logic [FIELD_BITS-1:0] dout_q;

	logic [W_BITS-1:0]     w_eff;
	logic [H_BITS-1:0]     h_eff;
	logic [INT_BITS-1:0]   xi, yi;
	logic [FRAC_BITS-1:0]  fx, fy;
	logic                  upper;
	logic                  outside;
	logic [WGT_BITS-1:0]   w00, w11, wc;
	logic [ADDR_BITS-1:0]  third_addr, far_addr;

	logic                  accept;
	logic                  ram_we;
	logic [ADDR_BITS-1:0]  ram_addr;
	logic [DEPTH_BITS-1:0] ram_rdata;
	logic                  z_bad;

	logic [MAC_A_BITS-1:0] mac_a;
	logic [MAC_B_BITS-1:0] mac_b;
	logic [ACC_BITS-1:0]   mac_c, mac_y;
	logic                  load_out, out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= SIZE_BITS'(256);
			image_height_q  <= SIZE_BITS'(256);
			invalid_depth_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:   image_width_q   <= SIZE_BITS'(cfg_data);
				CFG_IMAGE_HEIGHT:  image_height_q  <= SIZE_BITS'(cfg_data);
				CFG_INVALID_DEPTH: invalid_depth_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		w_eff = (32'(image_width_q) > 32'(MAX_WIDTH)) ? W_BITS'(MAX_WIDTH)
			: W_BITS'(image_width_q);
		h_eff = (32'(image_height_q) > 32'(MAX_HEIGHT)) ? H_BITS'(MAX_HEIGHT)
			: H_BITS'(image_height_q);
		xi    = INT_BITS'(qx_q >> FRAC_BITS);
		yi    = INT_BITS'(qy_q >> FRAC_BITS);
		fx    = qx_q[FRAC_BITS-1:0];
		fy    = qy_q[FRAC_BITS-1:0];
		upper = fx >= fy;
		outside = (32'(xi) + 32'd1 >= 32'(w_eff)) || (32'(yi) + 32'd1 >= 32'(h_eff));
		if (upper) begin
			w00 = FRAC_ONE - WGT_BITS'(fx);
			w11 = WGT_BITS'(fy);
			wc  = WGT_BITS'(fx) - WGT_BITS'(fy);
		end else begin
			w00 = FRAC_ONE - WGT_BITS'(fy);
			w11 = WGT_BITS'(fx);
			wc  = WGT_BITS'(fy) - WGT_BITS'(fx);
		end
		far_addr   = ADDR_BITS'(32'(base_q) + 32'(w_eff) + 32'd1);
		third_addr = upper ? ADDR_BITS'(32'(base_q) + 32'd1)
			: ADDR_BITS'(32'(base_q) + 32'(w_eff));
		z_bad = 32'(ram_rdata) == 32'(invalid_depth_q);
	end

	assign accept = start && (state_q == ST_IDLE);

	// sequencer: next state, store port and shared multiply-add operands
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = base_q;
		mac_a     = MAC_A_BITS'(ram_rdata);
		mac_b     = MAC_B_BITS'(wc);
		mac_c     = acc_q;
		load_out  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ram_addr = ADDR_BITS'(pixel_index);
				if (accept) begin
					if (mode == MODE_QUERY) begin
						state_d = ST_BASE;
					end else begin
						ram_we = 32'(pixel_index) < 32'(STORE_SIZE);
					end
				end
			end
			ST_BASE: begin
				mac_a = MAC_A_BITS'(yi);
				mac_b = MAC_B_BITS'(w_eff);
				mac_c = ACC_BITS'(xi);
				if (outside) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end else begin
					state_d = ST_RD0;
				end
			end
			ST_RD0: begin
				state_d = ST_RD1;
			end
			ST_RD1: begin
				ram_addr = far_addr;
				mac_b    = MAC_B_BITS'(w00);
				mac_c    = FRAC_HALF;
				state_d  = ST_RD2;
			end
			ST_RD2: begin
				ram_addr = third_addr;
				mac_b    = MAC_B_BITS'(w11);
				state_d  = ST_MAC3;
			end
			ST_MAC3: begin
				load_out  = 1'b1;
				out_valid = !bad_q && !z_bad;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= load_out;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q <= query_x;
			qy_q <= query_y;
		end
		if (state_q == ST_BASE) begin
			base_q <= ADDR_BITS'(mac_y);
			bad_q  <= 1'b0;
		end else if (state_q == ST_RD1 || state_q == ST_RD2) begin
			bad_q <= bad_q || z_bad;
		end
		acc_q <= mac_y;
		if (load_out) begin
			valid_q <= out_valid;
			dout_q  <= out_valid ? FIELD_BITS'(mac_y >> FRAC_BITS) : '0;
		end
	end

	dgti_ram #(
		.ADDR_W(ADDR_BITS),
		.DATA_W(DEPTH_BITS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(DEPTH_BITS'(depth_in)),
		.rdata(ram_rdata)
	);

	dgti_mac u_mac (
		.a(mac_a),
		.b(mac_b),
		.c(mac_c),
		.y(mac_y)
	);

	assign busy        = state_q != ST_IDLE;
	assign done        = done_q;
	assign depth_valid = valid_q;
	assign depth_out   = dout_q;

endmodule

>>> src/dgti_checker.sv
// dgti_checker: port-level checks of the interpolator, bound to the top level
// depends on dgti_pkg for field widths

module dgti_checker
	import dgti_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  mode,
	input logic                  done,
	input logic                  depth_valid,
	input logic [FIELD_BITS-1:0] depth_out
);

	// a result only follows a busy cycle of a query
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !busy)
		else $error("result without a query in progress");

	a_query_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == MODE_QUERY |=> busy)
		else $error("query item did not start work");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == MODE_WRITE |=> !busy && !done)
		else $error("pixel write caused work or a result");

	a_invalid_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !depth_valid |-> depth_out == '0)
		else $error("invalid result with nonzero depth");

endmodule

bind depth_grid_triangle_interpolator dgti_checker u_dgti_checker (.*);
